FILE: hw/rtl/nats_pkg.sv
// ----------------------------------------------------------------------------
// nats_pkg
// shared constants, codes and types of the affinity thread scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package nats_pkg;

  localparam int MAX_THREADS = 16;
  localparam int SLOT_W      = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);
  localparam int CMP_W       = (CNT_W > 4) ? CNT_W : 4;

  localparam int WIN_W       = 16;
  localparam int MODEL_W     = 16;
  // age only has to tell whether it passed the largest window
  localparam int AGE_W       = WIN_W + 1;
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(100);

  localparam int IN_DATA_W   = 24;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 16;

  // operation codes carried in the input tuser
  localparam logic [1:0] FUNC_CREATE = 2'd0;
  localparam logic [1:0] FUNC_SET    = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  // thread state codes
  localparam logic [2:0] ST_READY       = 3'd0;
  localparam logic [2:0] ST_RUNNING     = 3'd1;
  localparam logic [2:0] ST_NPU_PENDING = 3'd2;
  localparam logic [2:0] ST_NPU_BURST   = 3'd3;

  typedef struct packed {
    logic load_in;
    logic execute;
  } dp_cmd_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } pick_t;

  // highest set bit of a slot vector
  function automatic pick_t newest(input logic [MAX_THREADS-1:0] v);
    pick_t p;
    p.found = 1'b0;
    p.idx   = '0;
    for (int i = 0; i < MAX_THREADS; i++) begin
      if (v[i]) begin
        p.found = 1'b1;
        p.idx   = SLOT_W'(i);
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/nats_ctrl.sv
// ----------------------------------------------------------------------------
// nats_ctrl
// handshake controller: takes one transaction, runs it, holds the result
// ----------------------------------------------------------------------------
`default_nettype none

module nats_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output nats_pkg::dp_cmd_t     cmd
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   exec;

  always_comb begin
    exec          = 1'b0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // result register must be free or emptying this cycle
        if (!out_valid_r || out_tready) begin
          exec          = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready   = (state_r == S_IDLE);
  assign out_tvalid  = out_valid_r;
  assign cmd.load_in = in_tready && in_tvalid;
  assign cmd.execute = exec;

endmodule

`default_nettype wire

FILE: hw/rtl/nats_datapath.sv
// ----------------------------------------------------------------------------
// nats_datapath
// thread table, affinity state, newest-slot pickers and result register
// ----------------------------------------------------------------------------
`default_nettype none

module nats_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire nats_pkg::dp_cmd_t                     cmd,
  input  wire logic [nats_pkg::IN_DATA_W-1:0]        in_tdata,
  input  wire logic [nats_pkg::IN_USER_W-1:0]        in_tuser,
  input  wire logic                                  cfg_valid,
  input  wire logic [nats_pkg::WIN_W-1:0]            cfg_data,
  output logic [nats_pkg::OUT_DATA_W-1:0]            out_tdata
);

  localparam int N = nats_pkg::MAX_THREADS;
  localparam int SW = nats_pkg::SLOT_W;

  // latched transaction
  logic [1:0]                     func_r;
  logic [3:0]                     thread_r;
  logic [2:0]                     nstate_r;
  logic [nats_pkg::MODEL_W-1:0]   model_r;
  logic                           locked_r;

  // table and scheduler state
  logic [2:0]                     slot_state_r [N];
  logic [nats_pkg::MODEL_W-1:0]   slot_model_r [N];
  logic [2:0]                     slot_state_nxt [N];
  logic [nats_pkg::MODEL_W-1:0]   slot_model_nxt [N];
  logic [nats_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [nats_pkg::MODEL_W-1:0]   active_r, active_nxt;
  logic [nats_pkg::AGE_W-1:0]     age_r, age_nxt;
  logic [SW-1:0]                  run_slot_r, run_slot_nxt;
  logic                           run_valid_r, run_valid_nxt;
  logic [nats_pkg::WIN_W-1:0]     window_r;

  logic [nats_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [N-1:0]                   used, pend_match, pend_any, ready;
  nats_pkg::pick_t                pick_match, pick_any, pick_npu, pick_cpu;
  logic                           age_over;

  logic [3:0]                     o_new_thread, o_npu_thread, o_cpu_thread;
  logic                           o_full, o_granted, o_msw, o_cswitch;
  logic [nats_pkg::AGE_W-1:0]     age_base;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r   <= in_tuser;
      thread_r <= in_tdata[3:0];
      nstate_r <= in_tdata[6:4];
      model_r  <= in_tdata[22:7];
      locked_r <= in_tdata[23];
    end
  end

  // slot scan vectors
  always_comb begin
    for (int i = 0; i < N; i++) begin
      used[i]       = (nats_pkg::CMP_W'(i) < nats_pkg::CMP_W'(count_r));
      pend_any[i]   = used[i] && (slot_state_r[i] == nats_pkg::ST_NPU_PENDING);
      pend_match[i] = pend_any[i] && (slot_model_r[i] == active_r);
      ready[i]      = used[i] && (slot_state_r[i] == nats_pkg::ST_READY);
    end
  end

  assign pick_match = nats_pkg::newest(pend_match);
  assign pick_any   = nats_pkg::newest(pend_any);
  assign pick_cpu   = nats_pkg::newest(ready);
  assign age_over   = (age_r > nats_pkg::AGE_W'(window_r));
  assign pick_npu   = pick_match.found ? pick_match :
                      (age_over ? pick_any : '0);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      slot_state_nxt[i] = slot_state_r[i];
      slot_model_nxt[i] = slot_model_r[i];
    end
    count_nxt     = count_r;
    active_nxt    = active_r;
    age_nxt       = age_r;
    age_base      = age_r;
    run_slot_nxt  = run_slot_r;
    run_valid_nxt = run_valid_r;
    o_new_thread  = '0;
    o_full        = 1'b0;
    o_granted     = 1'b0;
    o_npu_thread  = '0;
    o_msw         = 1'b0;
    o_cswitch     = 1'b0;

    case (func_r)
      nats_pkg::FUNC_CREATE: begin
        if (count_r >= nats_pkg::CNT_W'(N)) begin
          o_full = 1'b1;
        end else begin
          slot_state_nxt[SW'(count_r)] = nats_pkg::ST_READY;
          slot_model_nxt[SW'(count_r)] = '0;
          o_new_thread                 = 4'(count_r);
          count_nxt                    = count_r + 1'b1;
        end
      end
      nats_pkg::FUNC_SET: begin
        if (nats_pkg::CMP_W'(thread_r) < nats_pkg::CMP_W'(count_r)) begin
          slot_state_nxt[SW'(thread_r)] = nstate_r;
          slot_model_nxt[SW'(thread_r)] = model_r;
        end
      end
      nats_pkg::FUNC_TICK: begin
        if (!locked_r) begin
          // npu side
          if (pick_npu.found) begin
            if (slot_model_r[pick_npu.idx] != active_r) begin
              active_nxt = slot_model_r[pick_npu.idx];
              age_base   = '0;
              o_msw      = 1'b1;
            end
            slot_state_nxt[pick_npu.idx] = nats_pkg::ST_NPU_BURST;
            o_granted    = 1'b1;
            o_npu_thread = 4'(pick_npu.idx);
          end
          // cpu side: granted slot was pending, so never the ready pick
          if (pick_cpu.found && !(run_valid_r && run_slot_r == pick_cpu.idx)) begin
            if (run_valid_r && slot_state_r[run_slot_r] == nats_pkg::ST_RUNNING) begin
              slot_state_nxt[run_slot_r] = nats_pkg::ST_READY;
            end
            slot_state_nxt[pick_cpu.idx] = nats_pkg::ST_RUNNING;
            run_slot_nxt  = pick_cpu.idx;
            run_valid_nxt = 1'b1;
            o_cswitch     = 1'b1;
          end
          age_nxt = (&age_base) ? age_base : age_base + 1'b1;
        end
      end
      default: ;
    endcase

    o_cpu_thread = run_valid_nxt ? 4'(run_slot_nxt) : 4'd0;
    out_data_nxt = {o_cpu_thread, o_cswitch, o_msw, o_npu_thread,
                    o_granted, o_full, o_new_thread};
  end

  // table storage, written once per transaction
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      for (int i = 0; i < N; i++) begin
        slot_state_r[i] <= slot_state_nxt[i];
        slot_model_r[i] <= slot_model_nxt[i];
      end
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      active_r    <= '0;
      age_r       <= '0;
      run_slot_r  <= '0;
      run_valid_r <= 1'b0;
      window_r    <= nats_pkg::WINDOW_RESET;
    end else begin
      if (cfg_valid) begin
        window_r <= cfg_data;
      end
      if (cmd.execute) begin
        count_r     <= count_nxt;
        active_r    <= active_nxt;
        age_r       <= age_nxt;
        run_slot_r  <= run_slot_nxt;
        run_valid_r <= run_valid_nxt;
      end
    end
  end

  assign out_tdata = out_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/npu_affinity_thread_scheduler_core.sv
// ----------------------------------------------------------------------------
// npu_affinity_thread_scheduler_core
// thread table scheduler with npu model affinity and a cpu ready picker
// ----------------------------------------------------------------------------
// flow: each accepted transaction is latched, then the controller's execute state
//   updates the table and the result register; no new transaction is taken
//   until that execute is done, and it waits while out_tready stalls a held result
// reset: synchronous, active low; slot count, running thread, active model and
//   age clear, affinity window returns to 100; slot contents are not cleared
//   since slots beyond the count are never scanned
`default_nettype none

module npu_affinity_thread_scheduler_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // thread[3:0], new_state[6:4], model[22:7], npu_locked[23]
  input  wire logic [nats_pkg::IN_DATA_W-1:0]     in_tdata,
  // func[1:0]
  input  wire logic [nats_pkg::IN_USER_W-1:0]     in_tuser,
  // result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // new_thread[3:0], table_full[4], npu_granted[5], npu_thread[9:6],
  // npu_model_switch[10], cpu_switched[11], cpu_thread[15:12]
  output logic [nats_pkg::OUT_DATA_W-1:0]         out_tdata,
  // affinity window register write
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [nats_pkg::WIN_W-1:0]         cfg_data
);

  nats_pkg::dp_cmd_t cmd;

  // window writes are always taken
  assign cfg_ready = 1'b1;

  // controller: accept, execute once the result register is free
  nats_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // datapath: table, pickers over the used slots, result register
  nats_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

FILE: dv/sched_affinity_checker.sv
// ----------------------------------------------------------------------------
// sched_affinity_checker
// watches the scheduler channels, predicts every result and compares it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sched_affinity_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  // thread[3:0], new_state[6:4], model[22:7], npu_locked[23]
  input  wire logic [nats_pkg::IN_DATA_W-1:0] in_tdata,
  // func[1:0]
  input  wire logic [nats_pkg::IN_USER_W-1:0] in_tuser,
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  // new_thread[3:0], table_full[4], npu_granted[5], npu_thread[9:6],
  // npu_model_switch[10], cpu_switched[11], cpu_thread[15:12]
  input  wire logic [nats_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [nats_pkg::WIN_W-1:0]     cfg_data,
  output int                                  mismatches,
  output int                                  awaiting
);

  typedef struct {
    logic [nats_pkg::SLOT_W-1:0] new_thread;
    logic                        table_full;
    logic                        npu_granted;
    logic [nats_pkg::SLOT_W-1:0] npu_thread;
    logic                        npu_model_switch;
    logic                        cpu_switched;
    logic [nats_pkg::SLOT_W-1:0] cpu_thread;
  } sched_result_t;

  // shadow of the thread table and scheduler state
  logic [2:0]                   slot_st  [nats_pkg::MAX_THREADS];
  logic [nats_pkg::MODEL_W-1:0] slot_mdl [nats_pkg::MAX_THREADS];
  int                           used_slots;
  logic [nats_pkg::MODEL_W-1:0] act_model;
  logic [31:0]                  age;
  logic [nats_pkg::SLOT_W-1:0]  run_slot;
  logic                         run_valid;
  logic [nats_pkg::WIN_W-1:0]   window;

  sched_result_t awaited_results[$];
  sched_result_t want;

  initial begin
    mismatches = 0;
    awaiting   = 0;
  end

  function automatic int newest_slot(logic [2:0] st, bit by_model,
                                     logic [nats_pkg::MODEL_W-1:0] mdl);
    for (int i = used_slots - 1; i >= 0; i--) begin
      if (slot_st[i] == st && (!by_model || slot_mdl[i] == mdl)) return i;
    end
    return -1;
  endfunction

  function automatic sched_result_t apply_sched_op(logic [1:0] func, logic [3:0] thr,
                                                   logic [2:0] nst,
                                                   logic [nats_pkg::MODEL_W-1:0] mdl,
                                                   logic locked);
    sched_result_t r;
    int n;
    int c;
    r = '{default: '0};
    if (func == nats_pkg::FUNC_CREATE) begin
      if (used_slots >= nats_pkg::MAX_THREADS) begin
        r.table_full = 1'b1;
      end else begin
        slot_st[used_slots]  = nats_pkg::ST_READY;
        slot_mdl[used_slots] = '0;
        r.new_thread = nats_pkg::SLOT_W'(used_slots);
        used_slots++;
      end
    end else if (func == nats_pkg::FUNC_SET) begin
      if (int'(thr) < used_slots) begin
        slot_st[thr]  = nst;
        slot_mdl[thr] = mdl;
      end
    end else if (func == nats_pkg::FUNC_TICK && !locked) begin
      n = newest_slot(nats_pkg::ST_NPU_PENDING, 1'b1, act_model);
      if (n < 0 && age > {16'd0, window}) n = newest_slot(nats_pkg::ST_NPU_PENDING, 1'b0, '0);
      if (n >= 0) begin
        if (slot_mdl[n] != act_model) begin
          act_model = slot_mdl[n];
          age = '0;
          r.npu_model_switch = 1'b1;
        end
        slot_st[n] = nats_pkg::ST_NPU_BURST;
        r.npu_granted = 1'b1;
        r.npu_thread  = nats_pkg::SLOT_W'(n);
      end
      c = newest_slot(nats_pkg::ST_READY, 1'b0, '0);
      if (c >= 0 && !(run_valid && run_slot == nats_pkg::SLOT_W'(c))) begin
        // a thread still running gives the cpu back
        if (run_valid && slot_st[run_slot] == nats_pkg::ST_RUNNING) begin
          slot_st[run_slot] = nats_pkg::ST_READY;
        end
        run_slot  = nats_pkg::SLOT_W'(c);
        run_valid = 1'b1;
        slot_st[c] = nats_pkg::ST_RUNNING;
        r.cpu_switched = 1'b1;
      end
      if (age != 32'hFFFF_FFFF) age++;
    end
    r.cpu_thread = run_valid ? run_slot : '0;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      used_slots = 0;
      act_model  = '0;
      age        = '0;
      run_slot   = '0;
      run_valid  = 1'b0;
      window     = nats_pkg::WINDOW_RESET;
      for (int i = 0; i < nats_pkg::MAX_THREADS; i++) begin
        slot_st[i]  = '0;
        slot_mdl[i] = '0;
      end
      awaited_results.delete();
    end else begin
      // result first, popped before the input of the same cycle is pushed
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual %h",
                   $time, out_tdata);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("new_thread", want.new_thread, out_tdata[3:0]);
          check_field("table_full", want.table_full, out_tdata[4]);
          check_field("npu_granted", want.npu_granted, out_tdata[5]);
          check_field("npu_thread", want.npu_thread, out_tdata[9:6]);
          check_field("npu_model_switch", want.npu_model_switch, out_tdata[10]);
          check_field("cpu_switched", want.cpu_switched, out_tdata[11]);
          check_field("cpu_thread", want.cpu_thread, out_tdata[15:12]);
        end
      end
      if (cfg_valid && cfg_ready) window = cfg_data;
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(apply_sched_op(in_tuser, in_tdata[3:0], in_tdata[6:4],
                                                 in_tdata[22:7], in_tdata[23]));
      end
    end
    awaiting = awaited_results.size();
  end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the affinity thread scheduler: directed corner
// cases, then random phases with several window settings and idle patterns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  // codes the package leaves unnamed
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [2:0] ST_BLOCKED  = 3'd4;

  localparam int PHASE_ITEMS = 250;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic [nats_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic [nats_pkg::IN_USER_W-1:0]  in_tuser   = '0;
  logic                            out_tready = 1'b0;
  logic                            cfg_valid  = 1'b0;
  logic [nats_pkg::WIN_W-1:0]      cfg_data   = '0;
  wire logic                       in_tready;
  wire logic                       out_tvalid;
  wire logic [nats_pkg::OUT_DATA_W-1:0] out_tdata;
  wire logic                       cfg_ready;

  int mismatches;
  int awaiting;
  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  int created       = 0;   // creates sent so far, to aim set operations at used slots

  logic [nats_pkg::WIN_W-1:0] phase_window [6];

  npu_affinity_thread_scheduler_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  sched_affinity_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side back-pressure, one decision per cycle
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // one input transaction; returns at the edge where it is taken
  task automatic send_op(logic [1:0] func, logic [3:0] thr, logic [2:0] st,
                         logic [nats_pkg::MODEL_W-1:0] mdl, logic locked);
    @(negedge clk);
    while ($urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {locked, mdl, st, thr};
    if (func == nats_pkg::FUNC_CREATE && created < nats_pkg::MAX_THREADS) created++;
    do @(posedge clk); while (!in_tready);
  endtask

  // drop valid and wait until every expected result has come back
  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  // window register write, started on a falling edge with the block idle
  task automatic write_window(logic [nats_pkg::WIN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed scheduler traffic, with some noise
  task automatic send_random_op;
    int                           pick;
    int                           sel;
    logic [3:0]                   thr;
    logic [2:0]                   st;
    logic [nats_pkg::MODEL_W-1:0] mdl;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_op(nats_pkg::FUNC_CREATE, 4'($urandom), 3'($urandom), 16'($urandom),
              1'($urandom));
    end else if (pick < 50) begin
      // set operation, usually on a slot in use
      if (created > 0 && $urandom_range(7) != 0) thr = 4'($urandom_range(created - 1));
      else thr = 4'($urandom_range(15));
      sel = $urandom_range(99);
      if (sel < 25) st = nats_pkg::ST_READY;
      else if (sel < 60) st = nats_pkg::ST_NPU_PENDING;
      else if (sel < 70) st = nats_pkg::ST_RUNNING;
      else if (sel < 80) st = nats_pkg::ST_NPU_BURST;
      else if (sel < 90) st = ST_BLOCKED;
      else st = 3'($urandom_range(7, 5));
      sel = $urandom_range(9);
      if (sel < 7) mdl = 16'($urandom_range(3));
      else if (sel == 7) mdl = 16'hFFFF;
      else mdl = 16'($urandom);
      send_op(nats_pkg::FUNC_SET, thr, st, mdl, 1'($urandom));
    end else if (pick < 92) begin
      send_op(nats_pkg::FUNC_TICK, 4'($urandom), 3'($urandom), 16'($urandom),
              ($urandom_range(99) < 15));
    end else if (pick < 96) begin
      send_op(FUNC_UNUSED, 4'($urandom), 3'($urandom), 16'($urandom), 1'($urandom));
    end else begin
      send_op(2'($urandom), 4'($urandom), 3'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    phase_window[0] = 16'd0;
    phase_window[1] = 16'hFFFF;
    phase_window[2] = 16'd3;
    phase_window[3] = 16'($urandom);
    phase_window[4] = 16'd1;
    phase_window[5] = 16'd20;

    rst_n = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed part under the reset window
    // tick on an empty table
    send_op(nats_pkg::FUNC_TICK, 4'd0, 3'd0, 16'd0, 1'b0);
    // unused function code
    send_op(FUNC_UNUSED, 4'hF, 3'd7, 16'hFFFF, 1'b1);
    // set before any slot exists
    send_op(nats_pkg::FUNC_SET, 4'd0, nats_pkg::ST_NPU_PENDING, 16'hFFFF, 1'b0);
    send_op(nats_pkg::FUNC_CREATE, 4'd0, 3'd0, 16'd0, 1'b0);
    // first cpu switch
    send_op(nats_pkg::FUNC_TICK, 4'd0, 3'd0, 16'd0, 1'b0);
    // current thread back to ready
    send_op(nats_pkg::FUNC_SET, 4'd0, nats_pkg::ST_READY, 16'd0, 1'b0);
    // same thread, no switch
    send_op(nats_pkg::FUNC_TICK, 4'd0, 3'd0, 16'd0, 1'b0);
    send_op(nats_pkg::FUNC_CREATE, 4'd0, 3'd0, 16'd0, 1'b0);
    send_op(nats_pkg::FUNC_CREATE, 4'd0, 3'd0, 16'd0, 1'b0);
    // pending on another model
    send_op(nats_pkg::FUNC_SET, 4'd1, nats_pkg::ST_NPU_PENDING, 16'd5, 1'b0);
    // inside window, no grant
    send_op(nats_pkg::FUNC_TICK, 4'd0, 3'd0, 16'd0, 1'b0);
    // pending on active model
    send_op(nats_pkg::FUNC_SET, 4'd2, nats_pkg::ST_NPU_PENDING, 16'd0, 1'b0);
    // affinity grant
    send_op(nats_pkg::FUNC_TICK, 4'd0, 3'd0, 16'd0, 1'b0);
    // state code never picked
    send_op(nats_pkg::FUNC_SET, 4'd2, 3'd7, 16'hFFFF, 1'b0);
    // slot beyond the count
    send_op(nats_pkg::FUNC_SET, 4'hF, 3'd5, 16'h8000, 1'b1);
    // locked tick
    send_op(nats_pkg::FUNC_TICK, 4'hF, 3'd7, 16'hFFFF, 1'b1);
    send_op(nats_pkg::FUNC_SET, 4'd0, ST_BLOCKED, 16'd0, 1'b0);
    // nothing ready
    send_op(nats_pkg::FUNC_TICK, 4'd0, 3'd0, 16'd0, 1'b0);
    send_op(nats_pkg::FUNC_SET, 4'd0, nats_pkg::ST_RUNNING, 16'd3, 1'b0);
    send_op(nats_pkg::FUNC_TICK, 4'd0, 3'd0, 16'd0, 1'b0);

    // random phases: two with heavier receiver stalls, two with heavier sender gaps, two clean
    for (int p = 0; p < 6; p++) begin
      drain();
      if (p < 2) begin
        in_gap_pct    = 35;
        out_stall_pct = 52;
      end else if (p < 4) begin
        in_gap_pct    = 52;
        out_stall_pct = 35;
      end else begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end
      write_window(phase_window[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_op();
    end

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
